@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr holds at every clock edge
`define ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// cond implies expr in the same cycle
`define ASSERT_IMPLIES(name, cond, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// cond implies expr in the next cycle
`define ASSERT_NEXT(name, cond, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

@@ hdl/cf16_pkg.sv @@
// ----------------------------------------------------------------------------
// cf16_pkg
// Types, constants and the CRC-16/Modbus byte update for the framer.
// ----------------------------------------------------------------------------
package cf16_pkg;

    localparam int CHANNELS    = 4;
    localparam int IN_FIELDS   = 4;
    localparam int SAMPLE_W    = 16;
    localparam int DATA_BYTES  = 2 * CHANNELS;
    localparam int FRAME_BYTES = DATA_BYTES + 2;
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [IDX_W-1:0] IDX_CRC_LO = IDX_W'(DATA_BYTES);
    localparam logic [IDX_W-1:0] IDX_CRC_HI = IDX_W'(DATA_BYTES + 1);

    typedef logic [DATA_BYTES-1:0][7:0]        frame_t;
    typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] samples_t;

    typedef struct packed {
        logic   valid;
        frame_t frame;
    } q_head_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

@@ hdl/four_channel_crc16_framer.sv @@
// ----------------------------------------------------------------------------
// four_channel_crc16_framer
// Four 16-bit samples in, ten-byte frame out: samples low byte first,
// then CRC-16/Modbus low and high byte, last byte flagged.
// ----------------------------------------------------------------------------
//   channel   handshake            payload
//   in        in_valid/in_ready    channel_0..channel_3
//   out       out_valid/out_ready  frame_byte, last_byte
//
// One frame leaves as ten byte transfers, one per cycle while out_ready
// holds, with frames back to back; the byte serializer sets that rate.
// The first byte passes the queue, the frame register and the output register.
// A two-frame queue sits between input and serializer; input stalls only
// when it is full. Output stalls hold the current byte.
// Reset clears control state only; data and byte registers are not reset.
// ----------------------------------------------------------------------------
module four_channel_crc16_framer
    import cf16_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] channel_0,
    input  logic [15:0] channel_1,
    input  logic [15:0] channel_2,
    input  logic [15:0] channel_3,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  frame_byte,
    output logic        last_byte
);

    q_head_t head;
    logic    pop;

    cf16_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .channel_0 (channel_0),
        .channel_1 (channel_1),
        .channel_2 (channel_2),
        .channel_3 (channel_3),
        .pop       (pop),
        .head      (head)
    );

    cf16_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_byte (frame_byte),
        .last_byte  (last_byte)
    );

endmodule

@@ hdl/cf16_front.sv @@
// ----------------------------------------------------------------------------
// cf16_front
// Accepts sample transfers, packs them into frame bytes and queues them.
// ----------------------------------------------------------------------------
module cf16_front
    import cf16_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [15:0]   channel_0,
    input  logic [15:0]   channel_1,
    input  logic [15:0]   channel_2,
    input  logic [15:0]   channel_3,
    input  logic          pop,
    output q_head_t       head
);

    `include "assert_macros.svh"

    logic [IN_FIELDS-1:0][SAMPLE_W-1:0] in_samples;
    samples_t                           samples;
    frame_t                             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]                  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]                  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]                  count_reg, count_next;
    logic                               push;
    logic                               do_pop;

    assign in_samples = {channel_3, channel_2, channel_1, channel_0};

    for (genvar i = 0; i < CHANNELS; i++) begin : g_ch
        if (i < IN_FIELDS) begin : g_in
            assign samples[i] = in_samples[i];
        end else begin : g_zero
            assign samples[i] = '0;
        end
    end

    assign in_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign do_pop   = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.frame = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = rd_ptr_reg + 1'b1;
        if (push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= frame_t'(samples);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ASSERT_ALWAYS(a_count_range, count_reg <= QCNT_W'(QUEUE_DEPTH), "queue count overflow")
    `ASSERT_NEXT(a_push_grows, push && !do_pop, count_reg == $past(count_reg) + 1'b1, "push lost")
    `ASSERT_IMPLIES(a_pop_nonempty, pop, head.valid, "pop from empty queue")

endmodule

@@ hdl/cf16_back.sv @@
// ----------------------------------------------------------------------------
// cf16_back
// Serializes one queued frame per pass, updating the CRC a byte at a time.
// ----------------------------------------------------------------------------
module cf16_back
    import cf16_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  q_head_t       head,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    frame_byte,
    output logic          last_byte
);

    `include "assert_macros.svh"

    logic              busy_reg, busy_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    frame_t            frame_reg, frame_next;
    logic [15:0]       crc_reg, crc_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;
    logic              advance;
    logic [15:0]       crc_upd;

    assign advance = !out_valid_reg || out_ready;
    assign crc_upd = crc_byte(crc_reg, frame_reg[0]);

    always_comb
    begin
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        frame_next     = frame_reg;
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        pop            = 1'b0;

        if (busy_reg && advance)
        begin
            out_valid_next = 1'b1;
            out_last_next  = 1'b0;
            idx_next       = idx_reg + 1'b1;
            if (idx_reg == IDX_CRC_HI)
            begin
                out_byte_next = crc_reg[15:8];
                out_last_next = 1'b1;
                busy_next     = 1'b0;
                idx_next      = '0;
            end
            else if (idx_reg == IDX_CRC_LO)
            begin
                out_byte_next = crc_reg[7:0];
            end
            else
            begin
                out_byte_next = frame_reg[0];
                crc_next      = crc_upd;
                frame_next    = frame_t'(frame_reg >> 8);
            end
        end
        else if (advance)
        begin
            out_valid_next = 1'b0;
        end

        if ((!busy_reg || (advance && idx_reg == IDX_CRC_HI)) && head.valid)
        begin
            pop        = 1'b1;
            frame_next = head.frame;
            crc_next   = CRC_INIT;
            idx_next   = '0;
            busy_next  = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg    <= frame_next;
        crc_reg      <= crc_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = out_byte_reg;
    assign last_byte  = out_last_reg;

    `ASSERT_ALWAYS(a_idx_range, idx_reg <= IDX_CRC_HI, "byte index out of range")
    `ASSERT_IMPLIES(a_idle_idx, !busy_reg, idx_reg == '0, "idle with nonzero index")
    `ASSERT_NEXT(a_idx_step, busy_reg && advance && idx_reg != IDX_CRC_HI && !pop, idx_reg == $past(idx_reg) + 1'b1, "byte index skipped")

endmodule

@@ verif/tb_four_channel_crc16_framer.sv @@
// ----------------------------------------------------------------------------
// tb_four_channel_crc16_framer
// Self-checking bench for the four-channel CRC-16/Modbus framer. A table of
// directed frames, then random frames, go through the input channel with
// random gaps. Each accepted frame is expanded into its ten expected bytes
// by a local CRC predictor. Every output transfer is compared with the
// oldest pending byte. The receiver also stalls at random, holds off once
// for a long stretch to back up the block, and the sender drains three times.
// ----------------------------------------------------------------------------
module tb_four_channel_crc16_framer;
    import cf16_pkg::*;

    localparam int RANDOM_FRAMES = 210;
    localparam int MAX_GAP       = 17;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_AT_XFER  = 400;
    localparam int HOLD_CYCLES   = 160;
    localparam int DRAIN_CYCLES  = 24;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_byte_t;

    typedef struct packed {
        logic [15:0] c0;
        logic [15:0] c1;
        logic [15:0] c2;
        logic [15:0] c3;
        logic        lead_known;
        logic [7:0]  lead;
    } dir_row_t;

    localparam int DIR_ROWS = 14;

    // lead: first byte on the wire, the low byte of channel_0
    dir_row_t dir_table [DIR_ROWS] = '{
        '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 8'h00},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF},
        '{16'h0001, 16'h0000, 16'h0000, 16'h0000, 1'b1, 8'h01},
        '{16'h8000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 8'h00},
        '{16'h0000, 16'h0000, 16'h0000, 16'h8000, 1'b1, 8'h00},
        '{16'h00FF, 16'hFF00, 16'h00FF, 16'hFF00, 1'b1, 8'hFF},
        '{16'hFF00, 16'h00FF, 16'hFF00, 16'h00FF, 1'b1, 8'h00},
        '{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b1, 8'h55},
        '{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b1, 8'hAA},
        '{16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 1'b0, 8'h00},
        '{16'hA001, 16'hFFFF, 16'h0000, 16'hA001, 1'b0, 8'h00},
        '{16'h0102, 16'h0304, 16'h0506, 16'h0708, 1'b1, 8'h02},
        '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 1'b1, 8'hFF},
        '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b1, 8'h00}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [15:0] channel_0;
    logic [15:0] channel_1;
    logic [15:0] channel_2;
    logic [15:0] channel_3;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  frame_byte;
    logic        last_byte;

    frame_byte_t pending_bytes [$];
    int          errors = 0;
    int          cycles = 0;

    four_channel_crc16_framer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .channel_0  (channel_0),
        .channel_1  (channel_1),
        .channel_2  (channel_2),
        .channel_3  (channel_3),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_byte (frame_byte),
        .last_byte  (last_byte)
    );

    always #4 clk = ~clk;

    // reflected LFSR, one data bit per step, LSB first
    function automatic logic [15:0] modbus_crc_update(input logic [15:0] crc,
                                                      input logic [7:0]  data);
        logic fb;
        int   i;
        for (i = 0; i < 8; i++)
        begin
            fb  = crc[0] ^ data[i];
            crc = crc >> 1;
            if (fb)
                crc = crc ^ CRC_POLY;
        end
        return crc;
    endfunction

    function automatic void predict_frame(input samples_t s, input logic lead_known,
                                          input logic [7:0] lead);
        logic [15:0] crc;
        logic [15:0] sample;
        logic [7:0]  lo;
        int          ch;
        crc = CRC_INIT;
        for (ch = 0; ch < CHANNELS; ch++)
        begin
            sample = (ch < IN_FIELDS) ? s[ch] : 16'h0000;
            lo     = (ch == 0 && lead_known) ? lead : sample[7:0];
            crc    = modbus_crc_update(crc, sample[7:0]);
            crc    = modbus_crc_update(crc, sample[15:8]);
            pending_bytes.push_back('{data: lo, last: 1'b0});
            pending_bytes.push_back('{data: sample[15:8], last: 1'b0});
        end
        pending_bytes.push_back('{data: crc[7:0], last: 1'b0});
        pending_bytes.push_back('{data: crc[15:8], last: 1'b1});
    endfunction

    // idle cycles before the next transfer; runs of zero now and then
    function automatic int draw_gap(inout int burst_left);
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 11) == 0)
        begin
            burst_left = $urandom_range(5, 25);
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic [15:0] random_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_frame(input samples_t s, input int gap, input logic lead_known,
                              input logic [7:0] lead);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        channel_0 <= s[0];
        channel_1 <= s[1];
        channel_2 <= s[2];
        channel_3 <= s[3];
        do
            @(posedge clk);
        while (!in_ready);
        predict_frame(s, lead_known, lead);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        samples_t s;
        int       tx_burst;
        int       n;
        int       c;
        tx_burst  = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        channel_0 = 16'h0000;
        channel_1 = 16'h0000;
        channel_2 = 16'h0000;
        channel_3 = 16'h0000;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (n = 0; n < DIR_ROWS; n++)
        begin
            s    = '0;
            s[0] = dir_table[n].c0;
            s[1] = dir_table[n].c1;
            s[2] = dir_table[n].c2;
            s[3] = dir_table[n].c3;
            send_frame(s, draw_gap(tx_burst), dir_table[n].lead_known, dir_table[n].lead);
        end
        wait_drained();

        for (n = 0; n < RANDOM_FRAMES; n++)
        begin
            if (n == RANDOM_FRAMES / 2)
                wait_drained();
            s = '0;
            for (c = 0; c < IN_FIELDS; c++)
                s[c] = random_sample();
            send_frame(s, draw_gap(tx_burst), 1'b0, 8'h00);
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && pending_bytes.size() == 0)
            $display("four_channel_crc16_framer verification clean");
        else
            $display("four_channel_crc16_framer verification failed");
        $finish;
    end

    // receiver: random stalls, one long hold-off to back up the frame queue
    initial
    begin
        int   rx_wait;
        int   rx_burst;
        int   hold_left;
        int   xfers;
        logic hold_done;
        rx_wait   = 0;
        rx_burst  = 0;
        hold_left = 0;
        xfers     = 0;
        hold_done = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                xfers++;
                rx_wait = draw_gap(rx_burst);
                if (!hold_done && xfers >= HOLD_AT_XFER)
                begin
                    hold_left = HOLD_CYCLES;
                    hold_done = 1'b1;
                end
            end
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (rx_wait > 0)
            begin
                rx_wait--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        frame_byte_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_bytes.size() == 0)
            begin
                $display("%0t: unexpected transfer: expected none, actual byte %h last %b",
                         $time, frame_byte, last_byte);
                errors++;
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (frame_byte !== want.data)
                begin
                    $display("%0t: frame_byte mismatch: expected %h, actual %h",
                             $time, want.data, frame_byte);
                    errors++;
                end
                if (last_byte !== want.last)
                begin
                    $display("%0t: last_byte mismatch: expected %b, actual %b",
                             $time, want.last, last_byte);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("four_channel_crc16_framer verification failed");
            $finish;
        end
    end

endmodule

@@ four_channel_crc16_framer.f @@
+incdir+hdl
hdl/cf16_pkg.sv
hdl/cf16_front.sv
hdl/cf16_back.sv
hdl/four_channel_crc16_framer.sv
verif/tb_four_channel_crc16_framer.sv
